@@ src/rde_pkg.sv @@
// Shared types, codes and fixed-point helpers for the reaction-diffusion block.
// No dependencies; every other file imports this package.
package rde_pkg;

   typedef logic signed [31:0] word_type;
   typedef logic signed [63:0] wide_type;
   typedef logic        [30:0] ureg_type;

   typedef struct packed {
      word_type u;
      word_type v;
      word_type w;
   } cell_type;

   typedef struct packed {
      word_type    k1;
      word_type    k3;
      word_type    k4;
      ureg_type    inv_tau;
      ureg_type    dt;
      ureg_type    inv_dx_sq;
      logic        periodic;
      logic [15:0] steps;
   } cfg_type;

   typedef enum logic [2:0] {
      CSR_SOURCE_TERM    = 3'd0,
      CSR_V_COUPLING     = 3'd1,
      CSR_W_COUPLING     = 3'd2,
      CSR_INV_TAU        = 3'd3,
      CSR_TIME_STEP      = 3'd4,
      CSR_INV_DX_SQUARED = 3'd5,
      CSR_BOUNDARY_MODE  = 3'd6,
      CSR_STEPS_PER_RUN  = 3'd7
   } csr_index_type;

   // sequencer states of the top level
   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_FETCH_L, ST_FETCH_C, ST_START, ST_WAIT, ST_NEXT, ST_DONE
   } state_type;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_RUN   = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   localparam logic [1:0] KIND_WRITE   = 2'd0;
   localparam logic [1:0] KIND_RUN     = 2'd1;
   localparam logic [1:0] KIND_READ    = 2'd2;
   localparam logic [1:0] KIND_RUN_SAT = 2'd3;

   // operation slots of the per-cell sequence
   localparam logic [3:0] OP_UU   = 4'd0;
   localparam logic [3:0] OP_LU   = 4'd1;
   localparam logic [3:0] OP_CUBE = 4'd2;
   localparam logic [3:0] OP_LV   = 4'd3;
   localparam logic [3:0] OP_LW   = 4'd4;
   localparam logic [3:0] OP_KV   = 4'd5;
   localparam logic [3:0] OP_KW   = 4'd6;
   localparam logic [3:0] OP_TV   = 4'd7;
   localparam logic [3:0] OP_SUM  = 4'd9;
   localparam logic [3:0] OP_DTU  = 4'd10;
   localparam logic [3:0] OP_DTV  = 4'd11;
   localparam logic [3:0] OP_DTW  = 4'd12;
   localparam logic [3:0] OP_END  = 4'd14;

   localparam wide_type WORD_MAX = 64'sd2147483647;
   localparam wide_type WORD_MIN = -64'sd2147483648;

   function automatic logic ovf(input wide_type x);
      return (x > WORD_MAX) || (x < WORD_MIN);
   endfunction

   function automatic word_type sat_word(input wide_type x);
      word_type r;
      if (x > WORD_MAX) r = 32'sh7fffffff;
      else if (x < WORD_MIN) r = 32'sh80000000;
      else r = x[31:0];
      return r;
   endfunction

   // round half up to Q11.20: floor((p + 2^19) / 2^20)
   function automatic wide_type rnd(input wide_type p);
      return (p + 64'sd524288) >>> 20;
   endfunction

   function automatic wide_type wext(input word_type x);
      return wide_type'(x);
   endfunction

   function automatic word_type uext(input ureg_type x);
      return $signed({1'b0, x});
   endfunction

endpackage

@@ src/rde_mem.sv @@
// Cell store: one synchronous memory of u, v and w per cell, with registered read data.
// Depends on rde_pkg for the cell type.
module rde_mem import rde_pkg::*; #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output cell_type      rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  cell_type      wr_data
);

   cell_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

endmodule

@@ src/rde_cell_unit.sv @@
// Per-cell Euler update: one shared 32x32 multiplier sequenced over eleven products.
// Depends on rde_pkg for types, operation slots and rounding helpers.
module rde_cell_unit import rde_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  cell_type left,
   input  cell_type cur,
   input  cell_type right,
   input  cfg_type  cfg,
   output logic     done,
   output cell_type result,
   output logic     sat
);

   logic     busy_ff, busy_in;
   logic [3:0] op_ff, op_in;
   cell_type cur_ff;
   word_type lsu_ff, lsv_ff, lsw_ff, dif_ff;
   word_type uu_ff, lu_ff, cube_ff, lv_ff, lw_ff, kv_ff, kw_ff, tv_ff;
   word_type ru_ff, rv_ff, rw_ff;
   cell_type new_ff;
   logic     sat_ff, sat_in;
   wide_type prod_ff;
   logic [3:0] tag_ff;
   logic     pvld_ff, pvld_in;

   word_type mul_a, mul_b;
   wide_type lsu_w, lsv_w, lsw_w, dif_w;
   wide_type q_w, nu_w, nv_w, nw_w, ru_w, rv_w, rw_w;
   word_type q_s;

   always_comb begin
      lsu_w = wext(left.u) + wext(right.u) - 2 * wext(cur.u);
      lsv_w = wext(left.v) + wext(right.v) - 2 * wext(cur.v);
      lsw_w = wext(left.w) + wext(right.w) - 2 * wext(cur.w);
      dif_w = wext(cur.u) - wext(cur.v);
   end

   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      pvld_in = busy_ff;
      unique case (op_ff)
         OP_UU:   begin mul_a = cur_ff.u;  mul_b = cur_ff.u;            end
         OP_LU:   begin mul_a = lsu_ff;    mul_b = uext(cfg.inv_dx_sq); end
         OP_CUBE: begin mul_a = uu_ff;     mul_b = cur_ff.u;            end
         OP_LV:   begin mul_a = lsv_ff;    mul_b = uext(cfg.inv_dx_sq); end
         OP_LW:   begin mul_a = lsw_ff;    mul_b = uext(cfg.inv_dx_sq); end
         OP_KV:   begin mul_a = cfg.k3;    mul_b = cur_ff.v;            end
         OP_KW:   begin mul_a = cfg.k4;    mul_b = cur_ff.w;            end
         OP_TV:   begin mul_a = dif_ff;    mul_b = uext(cfg.inv_tau);   end
         OP_DTU:  begin mul_a = uext(cfg.dt); mul_b = ru_ff;            end
         OP_DTV:  begin mul_a = uext(cfg.dt); mul_b = rv_ff;            end
         OP_DTW:  begin mul_a = uext(cfg.dt); mul_b = rw_ff;            end
         default: pvld_in = 1'b0;
      endcase
   end

   always_comb begin
      q_w  = rnd(prod_ff);
      q_s  = sat_word(q_w);
      nu_w = wext(cur_ff.u) + wext(q_s);
      nv_w = wext(cur_ff.v) + wext(q_s);
      nw_w = wext(cur_ff.w) + wext(q_s);
      ru_w = wext(cfg.k1) + 2 * wext(cur_ff.u) - wext(cube_ff) - wext(kv_ff)
           - wext(kw_ff) + wext(lu_ff);
      rv_w = wext(tv_ff) + wext(lv_ff);
      rw_w = wext(cur_ff.u) - wext(cur_ff.w) + wext(lw_ff);
   end

   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      sat_in  = sat_ff;
      if (start) begin
         busy_in = 1'b1;
         op_in   = OP_UU;
         sat_in  = ovf(lsu_w) | ovf(lsv_w) | ovf(lsw_w) | ovf(dif_w);
      end else if (busy_ff) begin
         op_in = op_ff + 4'd1;
         if (op_ff == OP_END) begin
            busy_in = 1'b0;
         end
         if (op_ff == OP_SUM) begin
            sat_in = sat_in | ovf(ru_w) | ovf(rv_w) | ovf(rw_w);
         end
      end
      if (pvld_ff) begin
         sat_in = sat_in | ovf(q_w);
         if (tag_ff == OP_DTU) sat_in = sat_in | ovf(nu_w);
         if (tag_ff == OP_DTV) sat_in = sat_in | ovf(nv_w);
         if (tag_ff == OP_DTW) sat_in = sat_in | ovf(nw_w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pvld_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pvld_ff <= pvld_in;
      end
      op_ff   <= op_in;
      sat_ff  <= sat_in;
      prod_ff <= wext(mul_a) * wext(mul_b);
      tag_ff  <= op_ff;
      if (start) begin
         cur_ff <= cur;
         lsu_ff <= sat_word(lsu_w);
         lsv_ff <= sat_word(lsv_w);
         lsw_ff <= sat_word(lsw_w);
         dif_ff <= sat_word(dif_w);
      end
      if (busy_ff && op_ff == OP_SUM) begin
         ru_ff <= sat_word(ru_w);
         rv_ff <= sat_word(rv_w);
         rw_ff <= sat_word(rw_w);
      end
      if (pvld_ff) begin
         unique case (tag_ff)
            OP_UU:   uu_ff   <= q_s;
            OP_LU:   lu_ff   <= q_s;
            OP_CUBE: cube_ff <= q_s;
            OP_LV:   lv_ff   <= q_s;
            OP_LW:   lw_ff   <= q_s;
            OP_KV:   kv_ff   <= q_s;
            OP_KW:   kw_ff   <= q_s;
            OP_TV:   tv_ff   <= q_s;
            OP_DTU:  new_ff.u <= sat_word(nu_w);
            OP_DTV:  new_ff.v <= sat_word(nv_w);
            OP_DTW:  new_ff.w <= sat_word(nw_w);
            default: ;
         endcase
      end
   end

   assign done   = busy_ff && (op_ff == OP_END);
   assign result = new_ff;
   assign sat    = sat_ff;

endmodule

@@ src/reaction_diffusion_euler_step.sv @@
// A write item is answered from a registered result; a read item passes through ST_READ,
// where the registered memory data is loaded into the result. A run item sweeps the grid
// once per Euler step, cell by cell, through one shared 32x32 multiplier that forms eleven
// products per cell, and its result is loaded in ST_DONE after the last step (directly,
// with no sweep, when steps_per_run is zero).
// The cell store is a single-port-read, single-port-write memory; reset needs no clearing.
module reaction_diffusion_euler_step import rde_pkg::*; #(
   parameter int GRID = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_cell_index,
   input  word_type    req_u_in,
   input  word_type    req_v_in,
   input  word_type    req_w_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output word_type    rsp_u_out,
   output word_type    rsp_v_out,
   output word_type    rsp_w_out,
   output logic [1:0]  rsp_resp_kind,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   localparam int AW = $clog2(GRID);
   localparam logic [AW-1:0] LAST = AW'(GRID - 1);

   state_type state_ff, state_in;
   cfg_type   cfg_ff;
   logic [AW-1:0] cell_ff;
   logic [15:0]   step_ff;
   cell_type  left_ff, cur_ff, next_ff, first_ff;
   logic      run_sat_ff, oob_ff;
   logic      rsp_valid_ff;
   word_type  rsp_u_ff, rsp_v_ff, rsp_w_ff;
   logic [1:0] rsp_kind_ff;

   logic      accept, slot_free, in_range, rsp_load;
   logic      rd_en, wr_en, start;
   logic [AW-1:0] rd_addr, wr_addr, left_src;
   cell_type  rd_data, wr_data, right, result;
   logic      done, cell_sat;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == ST_IDLE && slot_free);
   assign accept    = req_valid && !req_stall;
   assign in_range  = 32'(req_cell_index) < 32'(GRID);
   assign left_src  = cfg_ff.periodic ? LAST : AW'(1);
   assign right     = (cell_ff == LAST) ? (cfg_ff.periodic ? first_ff : left_ff) : rd_data;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority case (req_type)
                  REQ_RUN:  state_in = (cfg_ff.steps == 16'd0) ? ST_DONE : ST_FETCH_L;
                  REQ_READ: state_in = ST_READ;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ:    state_in = ST_IDLE;
         ST_FETCH_L: state_in = ST_FETCH_C;
         ST_FETCH_C: state_in = ST_START;
         ST_START:   state_in = ST_WAIT;
         ST_WAIT: begin
            if (done) begin
               if (cell_ff != LAST) state_in = ST_START;
               else if (step_ff + 16'd1 == cfg_ff.steps) state_in = ST_DONE;
               else state_in = ST_NEXT;
            end
         end
         ST_NEXT:    state_in = ST_FETCH_L;
         ST_DONE:    state_in = slot_free ? ST_IDLE : ST_DONE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rd_en    = 1'b0;
      rd_addr  = AW'(req_cell_index);
      wr_en    = 1'b0;
      wr_addr  = AW'(req_cell_index);
      wr_data  = '{u: req_u_in, v: req_v_in, w: req_w_in};
      start    = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_type == REQ_WRITE) begin
               wr_en    = in_range;
               rsp_load = 1'b1;
            end
            if (accept && req_type == REQ_READ) begin
               rd_en = 1'b1;
            end
            if (accept && req_type == REQ_RUN) begin
               rd_en   = 1'b1;
               rd_addr = left_src;
            end
         end
         ST_READ:    rsp_load = 1'b1;
         ST_NEXT: begin
            rd_en   = 1'b1;
            rd_addr = left_src;
         end
         ST_FETCH_L: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         ST_FETCH_C: begin
            rd_en   = 1'b1;
            rd_addr = AW'(1);
         end
         ST_START:   start = 1'b1;
         ST_WAIT: begin
            wr_en   = done;
            wr_addr = cell_ff;
            wr_data = result;
            // fetch the right neighbour of the next cell
            rd_en   = done && cell_ff != LAST && cell_ff + AW'(1) != LAST;
            rd_addr = cell_ff + AW'(2);
         end
         ST_DONE:    rsp_load = slot_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         cfg_ff       <= '{k1: '0, k3: '0, k4: '0, inv_tau: 31'd1048576, dt: 31'd1048,
                           inv_dx_sq: 31'd1048576, periodic: 1'b0, steps: 16'd1};
      end else begin
         state_ff <= state_in;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_IDLE) step_ff <= '0;
         else if (state_ff == ST_WAIT && done && cell_ff == LAST) step_ff <= step_ff + 16'd1;
         if (csr_write_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_SOURCE_TERM:    cfg_ff.k1        <= csr_write_data;
               CSR_V_COUPLING:     cfg_ff.k3        <= csr_write_data;
               CSR_W_COUPLING:     cfg_ff.k4        <= csr_write_data;
               CSR_INV_TAU:        cfg_ff.inv_tau   <= csr_write_data[30:0];
               CSR_TIME_STEP:      cfg_ff.dt        <= csr_write_data[30:0];
               CSR_INV_DX_SQUARED: cfg_ff.inv_dx_sq <= csr_write_data[30:0];
               CSR_BOUNDARY_MODE:  cfg_ff.periodic  <= csr_write_data[0];
               CSR_STEPS_PER_RUN:  cfg_ff.steps     <= csr_write_data[15:0];
               default: ;
            endcase
         end
      end
      if (accept) begin
         oob_ff     <= !in_range;
         run_sat_ff <= 1'b0;
      end
      if (state_ff == ST_FETCH_L) left_ff <= rd_data;
      if (state_ff == ST_FETCH_C) begin
         cur_ff   <= rd_data;
         first_ff <= rd_data;
         cell_ff  <= '0;
      end
      if (state_ff == ST_START) next_ff <= right;
      if (state_ff == ST_WAIT && done) begin
         left_ff    <= cur_ff;
         cur_ff     <= next_ff;
         cell_ff    <= cell_ff + AW'(1);
         run_sat_ff <= run_sat_ff | cell_sat;
      end
      if (rsp_load) begin
         rsp_u_ff <= '0;
         rsp_v_ff <= '0;
         rsp_w_ff <= '0;
         unique case (state_ff)
            ST_READ: begin
               rsp_kind_ff <= KIND_READ;
               if (!oob_ff) begin
                  rsp_u_ff <= rd_data.u;
                  rsp_v_ff <= rd_data.v;
                  rsp_w_ff <= rd_data.w;
               end
            end
            ST_DONE: rsp_kind_ff <= run_sat_ff ? KIND_RUN_SAT : KIND_RUN;
            default: rsp_kind_ff <= KIND_WRITE;
         endcase
      end
   end

   rde_mem #(.DEPTH(GRID), .AW(AW)) u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   rde_cell_unit u_cell (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .left   (left_ff),
      .cur    (cur_ff),
      .right  (right),
      .cfg    (cfg_ff),
      .done   (done),
      .result (result),
      .sat    (cell_sat)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_u_out     = rsp_u_ff;
   assign rsp_v_out     = rsp_v_ff;
   assign rsp_w_out     = rsp_w_ff;
   assign rsp_resp_kind = rsp_kind_ff;

endmodule

@@ src/rde_chk.sv @@
// Port-level checker for the reaction-diffusion block, bound to the top level.
// Depends on rde_pkg for request and result codes.
module rde_chk import rde_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_type,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input word_type    rsp_u_out,
   input word_type    rsp_v_out,
   input word_type    rsp_w_out,
   input logic [1:0]  rsp_resp_kind
);

   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result pending right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_u_out) && $stable(rsp_resp_kind))
      else $error("stalled result changed");

   a_write_ack: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type == REQ_WRITE
      |=> rsp_valid && rsp_resp_kind == KIND_WRITE)
      else $error("write item not answered next cycle");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_resp_kind != KIND_READ
      |-> rsp_u_out == 0 && rsp_v_out == 0 && rsp_w_out == 0)
      else $error("non-read result carries data");

   a_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("item accepted while result slot blocked");

endmodule

bind reaction_diffusion_euler_step rde_chk u_rde_chk (.*);
